### rtl/tpgo_pkg.sv
// ----------------------------------------------------------------------------
// tpgo_pkg
// Shared constants, glyph font, stage payload types and the glyph bit lookup
// for the test-pattern glyph overlay pixel unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tpgo_pkg;

  // Port field widths
  localparam int XW     = 11;
  localparam int YW     = 12;
  localparam int CW     = 24;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  // Visible frame
  localparam int FRAME_WIDTH  = 1080;
  localparam int FRAME_HEIGHT = 2340;

  // Register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_FRAME_DIGIT = 3'd0,
    CFG_RUN_ID0     = 3'd1,
    CFG_RUN_ID1     = 3'd2,
    CFG_RUN_ID2     = 3'd3,
    CFG_RUN_ID3     = 3'd4
  } cfg_reg_t;

  // Colors 0xRRGGBB
  localparam logic [CW-1:0] COLOR_WHITE = 24'hffffff;
  localparam logic [CW-1:0] COLOR_BLACK = 24'h000000;
  localparam logic [CW-1:0] COLOR_GREEN = 24'h009640;

  // 3x5 hex font, row 0 in bits 14..12, leftmost column in the high bit
  localparam logic [15:0] GLYPH_BITS [16] = '{
    16'h7b6f, 16'h2492, 16'h73e7, 16'h73cf, 16'h5bc9, 16'h79cf, 16'h79ef, 16'h7249,
    16'h7bef, 16'h7bcf, 16'h7bed, 16'h6bae, 16'h7927, 16'h6b6e, 16'h79e7, 16'h79e4
  };

  // Stage 1 -> stage 2: coordinate offsets and region flags
  typedef struct packed {
    logic       inframe;
    logic [3:0] fsat;
    logic       green;
    logic       g0_ok;
    logic [8:0] dx0;
    logic       g1_ok;
    logic [8:0] dx1;
    logic [9:0] dy;
    logic       ft_ok;
    logic [9:0] fv;
    logic [3:0] fcx;
    logic [7:0] fy;
  } s1_t;

  // Stage 2 -> stage 3: glyph cells to look up
  typedef struct packed {
    logic       inframe;
    logic [3:0] fsat;
    logic       green;
    logic       g0_hit;
    logic [2:0] g0_row;
    logic [1:0] g0_col;
    logic       g1_hit;
    logic [2:0] g1_row;
    logic [1:0] g1_col;
    logic       ft_hit;
    logic [3:0] ft_nib;
    logic [2:0] ft_row;
    logic [1:0] ft_col;
  } s2_t;

  // Font bit of glyph g at (row, col); cells off the 3x5 grid read as blank
  function automatic logic glyph_bit(logic [3:0] g, logic [2:0] row, logic [1:0] col);
    logic [4:0] sh;
    logic [15:0] bits;
    sh   = 5'd14 - {1'b0, row, 1'b0} - {2'b00, row} - {3'b000, col};
    bits = GLYPH_BITS[g];
    if (row > 3'd4 || col > 2'd2) return 1'b0;
    return bits[sh[3:0]];
  endfunction

endpackage

`default_nettype wire

### rtl/tpgo_ifs.sv
// ----------------------------------------------------------------------------
// tpgo interfaces
// Valid/ready channels for pixel coordinates, pixel colors and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpgo_pix_if;
  logic                    valid;
  logic                    ready;
  logic [tpgo_pkg::XW-1:0] pixel_x;
  logic [tpgo_pkg::YW-1:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface tpgo_color_if;
  logic                    valid;
  logic                    ready;
  logic [tpgo_pkg::CW-1:0] pixel_color;
  modport source (output valid, pixel_color, input ready);
  modport sink   (input valid, pixel_color, output ready);
endinterface

interface tpgo_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tpgo_pkg::CFG_IW-1:0] index;
  logic [tpgo_pkg::CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/test_pattern_glyph_overlay_pixel_unit.sv
// An accepted coordinate reaches the output through the locate, cells and shade registers.
// Throughput: one item per cycle while the output is not stalled; three register stages (locate, cells, shade).
// A stalled output holds its color while earlier stages keep filling bubbles.
// Reset clears all stage valids, frame_digit and the run identifier to zero.
// Register writes are always ready and take effect in the cycle after they are accepted.
// ----------------------------------------------------------------------------
// test_pattern_glyph_overlay_pixel_unit
// Per-pixel test pattern: white background, two large digits, a sliding green
// block and a two-row footer with the run identifier in hex glyphs.
// ----------------------------------------------------------------------------
`default_nettype none

module test_pattern_glyph_overlay_pixel_unit #(
  parameter int FRAME_WIDTH  = tpgo_pkg::FRAME_WIDTH,
  parameter int FRAME_HEIGHT = tpgo_pkg::FRAME_HEIGHT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tpgo_pix_if.sink   pix_in,
  tpgo_color_if.source pix_out,
  tpgo_cfg_if.sink   cfg
);
  import tpgo_pkg::*;

  logic [3:0]       frame_digit;
  logic [3:0][31:0] run_id;
  logic             s1_valid;
  logic             s1_ready;
  s1_t              s1_data;
  logic             s2_valid;
  logic             s2_ready;
  s2_t              s2_data;

  // Register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_digit <= 4'd0;
      run_id      <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FRAME_DIGIT: frame_digit <= cfg.data[3:0];
        CFG_RUN_ID0:     run_id[0]   <= cfg.data;
        CFG_RUN_ID1:     run_id[1]   <= cfg.data;
        CFG_RUN_ID2:     run_id[2]   <= cfg.data;
        CFG_RUN_ID3:     run_id[3]   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pipeline
  tpgo_locate #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_locate (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (pix_in.valid),
    .in_ready    (pix_in.ready),
    .pixel_x     (pix_in.pixel_x),
    .pixel_y     (pix_in.pixel_y),
    .frame_digit (frame_digit),
    .out_valid   (s1_valid),
    .out_ready   (s1_ready),
    .out_data    (s1_data)
  );

  tpgo_cells u_cells (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .run_id    (run_id),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  tpgo_shade u_shade (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s2_valid),
    .in_ready    (s2_ready),
    .in_data     (s2_data),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .pixel_color (pix_out.pixel_color)
  );

endmodule

`default_nettype wire

### rtl/tpgo_locate.sv
// ----------------------------------------------------------------------------
// tpgo_locate
// Stage 1: frame check, layer bounds, offsets into each glyph area and the
// footer glyph column by reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module tpgo_locate #(
  parameter int FRAME_WIDTH  = tpgo_pkg::FRAME_WIDTH,
  parameter int FRAME_HEIGHT = tpgo_pkg::FRAME_HEIGHT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire logic [tpgo_pkg::XW-1:0] pixel_x,
  input  wire logic [tpgo_pkg::YW-1:0] pixel_y,
  input  wire logic [3:0]              frame_digit,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      tpgo_pkg::s1_t           out_data
);
  import tpgo_pkg::*;

  s1_t         data_next;
  logic [10:0] green_lo;
  logic [10:0] x_m150;
  logic [10:0] x_m600;
  logic [11:0] y_m650;
  logic [10:0] x_m60;
  logic [11:0] y_m2020;
  logic [20:0] prod;
  logic        gy_ok;

  // Offsets and region flags
  always_comb begin
    x_m150  = pixel_x - 11'd150;
    x_m600  = pixel_x - 11'd600;
    y_m650  = pixel_y - 12'd650;
    x_m60   = pixel_x - 11'd60;
    y_m2020 = pixel_y - 12'd2020;
    // x/60 as (x*1093)>>16, exact for x below 1024
    prod    = 21'(x_m60[9:0]) * 21'd1093;
    gy_ok   = pixel_y >= 12'd650 && pixel_y < 12'd1200;

    data_next.inframe = int'(pixel_x) < FRAME_WIDTH && int'(pixel_y) < FRAME_HEIGHT;
    data_next.fsat    = (frame_digit > 4'd9) ? 4'd9 : frame_digit;
    green_lo          = 11'd60 + 11'(data_next.fsat) * 11'd85;
    data_next.green   = pixel_y >= 12'd1420 && pixel_y < 12'd1740 &&
                        pixel_x >= green_lo && pixel_x < green_lo + 11'd180;
    data_next.g0_ok   = gy_ok && pixel_x >= 11'd150 && pixel_x < 11'd480;
    data_next.dx0     = x_m150[8:0];
    data_next.g1_ok   = gy_ok && pixel_x >= 11'd600 && pixel_x < 11'd930;
    data_next.dx1     = x_m600[8:0];
    data_next.dy      = y_m650[9:0];
    data_next.ft_ok   = pixel_x >= 11'd60 && pixel_x < 11'd1020 &&
                        pixel_y >= 12'd2020 && pixel_y < 12'd2180;
    data_next.fv      = x_m60[9:0];
    data_next.fcx     = prod[19:16];
    data_next.fy      = y_m2020[7:0];
  end

  assign in_ready = !out_valid || out_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

### rtl/tpgo_cells.sv
// ----------------------------------------------------------------------------
// tpgo_cells
// Stage 2: glyph row and column for every glyph layer, and the footer
// identifier nibble for the glyph under the pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module tpgo_cells (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire tpgo_pkg::s1_t       in_data,
  input  wire logic [3:0][31:0]    run_id,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      tpgo_pkg::s2_t       out_data
);
  import tpgo_pkg::*;

  s2_t        data_next;
  logic [2:0] big_row;
  logic [9:0] cx60;
  logic [9:0] dxg;
  logic       ry;
  logic [6:0] dyg;
  logic [4:0] gidx;
  logic [31:0] word;

  // Divide by 110 with compares
  function automatic logic [1:0] col110(logic [8:0] d);
    return (d >= 9'd220) ? 2'd2 : (d >= 9'd110) ? 2'd1 : 2'd0;
  endfunction

  always_comb begin
    // Large glyphs share the row
    big_row = (in_data.dy >= 10'd440) ? 3'd4 :
              (in_data.dy >= 10'd330) ? 3'd3 :
              (in_data.dy >= 10'd220) ? 3'd2 :
              (in_data.dy >= 10'd110) ? 3'd1 : 3'd0;

    // Footer cell offsets
    cx60 = {in_data.fcx, 6'd0} - {4'd0, in_data.fcx, 2'd0};
    dxg  = in_data.fv - cx60;
    ry   = in_data.fy >= 8'd80;
    dyg  = 7'(in_data.fy - (ry ? 8'd80 : 8'd0));
    gidx = {ry, in_data.fcx};
    word = run_id[gidx[4:3]];

    data_next.inframe = in_data.inframe;
    data_next.fsat    = in_data.fsat;
    data_next.green   = in_data.green;
    data_next.g0_hit  = in_data.g0_ok;
    data_next.g0_row  = big_row;
    data_next.g0_col  = col110(in_data.dx0);
    data_next.g1_hit  = in_data.g1_ok;
    data_next.g1_row  = big_row;
    data_next.g1_col  = col110(in_data.dx1);
    data_next.ft_hit  = in_data.ft_ok && dxg < 10'd24 && dyg < 7'd40;
    data_next.ft_nib  = word[{~gidx[2:0], 2'b00} +: 4];
    data_next.ft_row  = dyg[5:3];
    data_next.ft_col  = dxg[4:3];
  end

  assign in_ready = !out_valid || out_ready;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

### rtl/tpgo_shade.sv
// ----------------------------------------------------------------------------
// tpgo_shade
// Stage 3: font lookups and layer priority into the registered pixel color.
// ----------------------------------------------------------------------------
`default_nettype none

module tpgo_shade (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire tpgo_pkg::s2_t           in_data,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic [tpgo_pkg::CW-1:0] pixel_color
);
  import tpgo_pkg::*;

  logic [CW-1:0] color_next;

  // Later layers win
  always_comb begin
    color_next = COLOR_WHITE;
    if (in_data.inframe) begin
      if (in_data.g0_hit && glyph_bit(4'd0, in_data.g0_row, in_data.g0_col)) begin
        color_next = COLOR_BLACK;
      end
      if (in_data.g1_hit && glyph_bit(in_data.fsat, in_data.g1_row, in_data.g1_col)) begin
        color_next = COLOR_BLACK;
      end
      if (in_data.green) begin
        color_next = COLOR_GREEN;
      end
      if (in_data.ft_hit && glyph_bit(in_data.ft_nib, in_data.ft_row, in_data.ft_col)) begin
        color_next = COLOR_BLACK;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      pixel_color <= color_next;
    end
  end

  // Pixels off the frame come out white
  a_off_frame_white: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.inframe |=> pixel_color == COLOR_WHITE)
    else $error("off-frame pixel not white");

  // Green block rows never overlap the glyph rows
  a_layers_disjoint: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> !(in_data.green && (in_data.ft_hit || in_data.g0_hit || in_data.g1_hit)))
    else $error("green block overlaps a glyph area");

  // Only the three palette colors ever leave
  a_palette: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_color == COLOR_WHITE || pixel_color == COLOR_BLACK ||
                  pixel_color == COLOR_GREEN)
    else $error("color outside palette");

endmodule

`default_nettype wire

### sim/test_pattern_glyph_overlay_pixel_unit_test.sv
// ----------------------------------------------------------------------------
// test_pattern_glyph_overlay_pixel_unit_test
// Drives pixel coordinates into the test-pattern unit and checks every color
// against a predictor of the layered picture. The picture is a white
// background, two large digits, a sliding green block and a hex footer. The
// run goes through several register settings and idle/stall profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module test_pattern_glyph_overlay_pixel_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpgo_pkg::*;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } coord_t;

  // 3x5 hex font, row 0 in bits 14..12, leftmost column in the high bit
  localparam logic [15:0] HEX_FONT [16] = '{
    16'h7b6f, 16'h2492, 16'h73e7, 16'h73cf, 16'h5bc9, 16'h79cf, 16'h79ef, 16'h7249,
    16'h7bef, 16'h7bcf, 16'h7bed, 16'h6bae, 16'h7927, 16'h6b6e, 16'h79e7, 16'h79e4
  };

  // Picture layout
  localparam int BIG_SCALE    = 110;
  localparam int BIG_ROW      = 650;
  localparam int ZERO_COL     = 150;
  localparam int DIGIT_COL    = 600;
  localparam int BLOCK_TOP    = 1420;
  localparam int BLOCK_BOTTOM = 1740;
  localparam int BLOCK_LEFT   = 60;
  localparam int BLOCK_WIDE   = 180;
  localparam int BLOCK_STEP   = 85;
  localparam int FOOT_ROW     = 2020;
  localparam int FOOT_COL     = 60;
  localparam int FOOT_PITCH_X = 60;
  localparam int FOOT_PITCH_Y = 80;
  localparam int FOOT_SCALE   = 8;
  localparam int MAX_DIGIT    = 9;
  localparam int LATENCY      = 3;

  logic clk;
  logic rst;

  tpgo_pix_if   pix_in_if ();
  tpgo_color_if color_if ();
  tpgo_cfg_if   cfg_if ();

  test_pattern_glyph_overlay_pixel_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in_if),
    .pix_out (color_if),
    .cfg     (cfg_if)
  );

  // Register copy held by the predictor
  logic [3:0]        shown_frame;
  logic [CFG_DW-1:0] run_id_words [4];

  coord_t           coords_to_send [$];
  logic [CW-1:0]    expected_colors [$];
  int               send_idle_pct;
  int               recv_stall_pct;
  int               mismatches = 0;

  // Ink test for glyph g placed at (gx, gy) with scale s
  function automatic logic glyph_lit(int px, int py, int gx, int gy,
                                     logic [3:0] g, int s);
    int dx, dy, col, row;
    if (px < gx || py < gy) return 1'b0;
    dx = px - gx;
    dy = py - gy;
    if (dx >= 3 * s || dy >= 5 * s) return 1'b0;
    col = dx / s;
    row = dy / s;
    return HEX_FONT[g][14 - row * 3 - col];
  endfunction

  // Color of one pixel, later layers painted over earlier ones
  function automatic logic [CW-1:0] pattern_color(logic [XW-1:0] x, logic [YW-1:0] y);
    int            ux, uy, f, cx, ry, idx;
    logic [3:0]    nib;
    logic [CW-1:0] c;
    ux = int'(x);
    uy = int'(y);
    f  = (int'(shown_frame) > MAX_DIGIT) ? MAX_DIGIT : int'(shown_frame);
    c  = COLOR_WHITE;
    if (ux < FRAME_WIDTH && uy < FRAME_HEIGHT) begin
      if (glyph_lit(ux, uy, ZERO_COL, BIG_ROW, 4'd0, BIG_SCALE)) c = COLOR_BLACK;
      if (glyph_lit(ux, uy, DIGIT_COL, BIG_ROW, f[3:0], BIG_SCALE)) c = COLOR_BLACK;
      if (uy >= BLOCK_TOP && uy < BLOCK_BOTTOM && ux >= BLOCK_LEFT + f * BLOCK_STEP &&
          ux < BLOCK_LEFT + BLOCK_WIDE + f * BLOCK_STEP)
        c = COLOR_GREEN;
      if (ux >= FOOT_COL && uy >= FOOT_ROW) begin
        cx = (ux - FOOT_COL) / FOOT_PITCH_X;
        ry = (uy - FOOT_ROW) / FOOT_PITCH_Y;
        if (cx < 16 && ry < 2) begin
          idx = ry * 16 + cx;
          nib = 4'(run_id_words[idx / 8] >> (28 - 4 * (idx % 8)));
          if (glyph_lit(ux, uy, FOOT_COL + cx * FOOT_PITCH_X, FOOT_ROW + ry * FOOT_PITCH_Y,
                        nib, FOOT_SCALE))
            c = COLOR_BLACK;
        end
      end
    end
    return c;
  endfunction

  // Random coordinate, weighted toward the painted regions
  function automatic coord_t random_coord();
    coord_t c;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c.x = XW'($urandom_range(0, 2047));
      c.y = YW'($urandom_range(0, 4095));
    end else if (pick < 45) begin
      c.x = XW'($urandom_range(130, 960));
      c.y = YW'($urandom_range(630, 1220));
    end else if (pick < 65) begin
      c.x = XW'($urandom_range(40, FRAME_WIDTH - 1));
      c.y = YW'($urandom_range(1400, 1760));
    end else if (pick < 90) begin
      c.x = XW'($urandom_range(40, FRAME_WIDTH + 20));
      c.y = YW'($urandom_range(2000, 2200));
    end else begin
      c.x = XW'($urandom_range(0, FRAME_WIDTH - 1));
      c.y = YW'($urandom_range(0, FRAME_HEIGHT - 1));
    end
    return c;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Coordinate driver: valid held until accepted, gaps taken at random
  always @(posedge clk) begin
    if (rst) begin
      pix_in_if.valid   <= 1'b0;
      pix_in_if.pixel_x <= '0;
      pix_in_if.pixel_y <= '0;
    end else begin
      if (pix_in_if.valid && pix_in_if.ready)
        expected_colors.push_back(pattern_color(pix_in_if.pixel_x, pix_in_if.pixel_y));
      if (!pix_in_if.valid || pix_in_if.ready) begin
        if (coords_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          coord_t c;
          c = coords_to_send.pop_front();
          pix_in_if.valid   <= 1'b1;
          pix_in_if.pixel_x <= c.x;
          pix_in_if.pixel_y <= c.y;
        end else begin
          pix_in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Color monitor: compare each accepted color with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      color_if.ready <= 1'b0;
    end else begin
      if (color_if.valid && color_if.ready) begin
        if (expected_colors.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected color, expected none, actual %06h", $time,
                   color_if.pixel_color);
        end else begin
          logic [CW-1:0] want;
          want = expected_colors.pop_front();
          if (color_if.pixel_color !== want) begin
            mismatches++;
            $display("%0t: pixel_color mismatch, expected %06h, actual %06h", $time,
                     want, color_if.pixel_color);
          end
        end
      end
      color_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // One register write; the predictor copy follows the accepted write
  task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_FRAME_DIGIT: shown_frame = value[3:0];
      CFG_RUN_ID0:     run_id_words[0] = value;
      CFG_RUN_ID1:     run_id_words[1] = value;
      CFG_RUN_ID2:     run_id_words[2] = value;
      CFG_RUN_ID3:     run_id_words[3] = value;
      default: ;  // out-of-range index is dropped
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all(input logic [3:0] frame, input logic [CFG_DW-1:0] w0,
                           input logic [CFG_DW-1:0] w1, input logic [CFG_DW-1:0] w2,
                           input logic [CFG_DW-1:0] w3);
    write_register(CFG_FRAME_DIGIT, {28'd0, frame});
    write_register(CFG_RUN_ID0, w0);
    write_register(CFG_RUN_ID1, w1);
    write_register(CFG_RUN_ID2, w2);
    write_register(CFG_RUN_ID3, w3);
    @(negedge clk);
  endtask

  // Wait until every queued item went in and every color came out
  task automatic drain();
    @(negedge clk);
    while (coords_to_send.size() != 0 || pix_in_if.valid || expected_colors.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) coords_to_send.push_back(random_coord());
  endtask

  task automatic queue_at(input int x, input int y);
    coord_t c;
    c.x = XW'(x);
    c.y = YW'(y);
    coords_to_send.push_back(c);
  endtask

  // Stimulus and phase control
  initial begin
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    shown_frame    = '0;
    run_id_words   = '{default: '0};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: corners, frame edge, glyph and block borders, footer cells
    queue_at(0, 0);
    queue_at(FRAME_WIDTH - 1, FRAME_HEIGHT - 1);
    queue_at(FRAME_WIDTH, 1500);
    queue_at(200, FRAME_HEIGHT);
    queue_at(2047, 4095);
    queue_at(0, 4095);
    queue_at(2047, 0);
    queue_at(150, 650);
    queue_at(149, 650);
    queue_at(479, 1199);
    queue_at(480, 1199);
    queue_at(315, 925);      // hole in the zero
    queue_at(600, 650);
    queue_at(929, 1199);
    queue_at(60, 1420);
    queue_at(239, 1739);
    queue_at(240, 1420);
    queue_at(59, 1739);
    queue_at(60, 2020);
    queue_at(83, 2059);
    queue_at(84, 2020);
    queue_at(960, 2100);
    queue_at(983, 2139);
    queue_at(1020, 2100);
    queue_random(90);
    drain();

    // Highest proper digit, every hex nibble in the footer; sender gaps
    write_all(4'd9, 32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
    send_idle_pct = 59;
    queue_random(90);
    drain();

    // Saturated frame, all-ones identifier, dropped writes; receiver stalls
    write_all(4'd15, '1, '1, '1, '1);
    for (int k = CFG_RUN_ID3 + 1; k < (1 << CFG_IW); k++)
      write_register(k[CFG_IW-1:0], $urandom);
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    queue_random(90);
    drain();

    // Random settings, both sides idling; full pause halfway
    write_all(4'($urandom_range(0, 15)), $urandom, $urandom, $urandom, $urandom);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    queue_random(45);
    drain();
    queue_random(45);
    drain();

    // Back to the low extreme with no idling
    write_all(4'd0, '0, '0, '0, '0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(90);
    drain();

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
